// ----- rtl/float_literal_validator_assert.svh -----
// Assertion macros shared by the float literal validator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FLOAT_LITERAL_VALIDATOR_ASSERT_SVH
`define FLOAT_LITERAL_VALIDATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FLV_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("float literal validator: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define FLV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("float literal validator: next-cycle check failed");

`endif

// ----- rtl/flv_pkg.sv -----
// Package for the float literal validator: status codes, character constants,
// register indexes and the step struct. Depends on nothing.
package flv_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_EXTRA_E      = 3'd1,
        ST_EXTRA_POINT  = 3'd2,
        ST_POINT_IN_EXP = 3'd3,
        ST_BAD_SIGN     = 3'd4,
        ST_BAD_CHAR     = 3'd5,
        ST_MANT_LONG    = 3'd6,
        ST_EXP_LONG     = 3'd7
    } flv_status_t;

    // Configuration register indexes.
    localparam logic CFG_IDX_MANT = 1'b0;
    localparam logic CFG_IDX_EXP  = 1'b1;

    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] COUNT_MAX      = 7'd127;
    localparam logic [CNT_W-1:0] MANT_LIMIT_RST = 7'd30;
    localparam logic [CNT_W-1:0] EXP_LIMIT_RST  = 7'd5;

    // ASCII codes.
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // One character step handed from the input stage to the scanner.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] char_code;
    } flv_step_t;

endpackage

// ----- rtl/flv_scan.sv -----
// Per-string syntax state of the float literal validator and the status verdict.
// Depends on flv_pkg and float_literal_validator_assert.svh.
`include "float_literal_validator_assert.svh"

module flv_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  flv_pkg::flv_step_t            step,
    input  logic [flv_pkg::CNT_W-1:0]     mant_limit,
    input  logic [flv_pkg::CNT_W-1:0]     exp_limit,
    output flv_pkg::flv_status_t          verdict
);

    logic                      at_first_reg,   at_first_next;
    logic                      seen_e_reg,     seen_e_next;
    logic                      prev_e_reg,     prev_e_next;
    logic                      seen_point_reg, seen_point_next;
    logic                      mant_sign_reg,  mant_sign_next;
    logic                      exp_sign_reg,   exp_sign_next;
    logic [flv_pkg::CNT_W-1:0] mant_cnt_reg,   mant_cnt_next;
    logic [flv_pkg::CNT_W-1:0] exp_cnt_reg,    exp_cnt_next;
    flv_pkg::flv_status_t      err_reg,        err_next;

    // Values after examining the character, before the end-of-string clear.
    logic                      seen_e_upd, prev_e_upd, seen_point_upd;
    logic                      mant_sign_upd, exp_sign_upd;
    logic [flv_pkg::CNT_W-1:0] mant_cnt_upd, exp_cnt_upd;
    flv_pkg::flv_status_t      err_upd;
    logic                      is_digit, is_mark, is_sign;

    assign is_digit = (step.char_code >= flv_pkg::CH_ZERO) &&
                      (step.char_code <= flv_pkg::CH_NINE);
    assign is_mark  = (step.char_code == flv_pkg::CH_LOWER_E) ||
                      (step.char_code == flv_pkg::CH_UPPER_E);
    assign is_sign  = (step.char_code == flv_pkg::CH_PLUS) ||
                      (step.char_code == flv_pkg::CH_MINUS);

    // Character rules; the first error freezes everything but the first-char flag.
    always_comb begin
        seen_e_upd     = seen_e_reg;
        prev_e_upd     = prev_e_reg;
        seen_point_upd = seen_point_reg;
        mant_sign_upd  = mant_sign_reg;
        exp_sign_upd   = exp_sign_reg;
        mant_cnt_upd   = mant_cnt_reg;
        exp_cnt_upd    = exp_cnt_reg;
        err_upd        = err_reg;
        if (err_reg == flv_pkg::ST_OK) begin
            prev_e_upd = 1'b0;
            if (is_digit) begin
                if (!seen_e_reg) begin
                    if (mant_cnt_reg != flv_pkg::COUNT_MAX) begin
                        mant_cnt_upd = mant_cnt_reg + 7'd1;
                    end
                end else if (exp_cnt_reg != flv_pkg::COUNT_MAX) begin
                    exp_cnt_upd = exp_cnt_reg + 7'd1;
                end
            end else if (is_mark) begin
                if (seen_e_reg) begin
                    err_upd = flv_pkg::ST_EXTRA_E;
                end
                seen_e_upd = 1'b1;
                prev_e_upd = 1'b1;
            end else if (step.char_code == flv_pkg::CH_POINT) begin
                if (seen_point_reg) begin
                    err_upd = flv_pkg::ST_EXTRA_POINT;
                end else if (seen_e_reg) begin
                    err_upd = flv_pkg::ST_POINT_IN_EXP;
                end
                seen_point_upd = 1'b1;
            end else if (is_sign) begin
                if (!seen_e_reg && !mant_sign_reg && at_first_reg) begin
                    mant_sign_upd = 1'b1;
                end else if (seen_e_reg && prev_e_reg && !exp_sign_reg) begin
                    exp_sign_upd = 1'b1;
                end else begin
                    err_upd = flv_pkg::ST_BAD_SIGN;
                end
            end else begin
                err_upd = flv_pkg::ST_BAD_CHAR;
            end
        end
    end

    // Verdict: length limits override any earlier error, exponent last.
    always_comb begin
        verdict = err_upd;
        if (mant_cnt_upd > mant_limit) begin
            verdict = flv_pkg::ST_MANT_LONG;
        end
        if (exp_cnt_upd > exp_limit) begin
            verdict = flv_pkg::ST_EXP_LONG;
        end
    end

    // Next state: hold when idle, clear after the final character.
    always_comb begin
        at_first_next   = at_first_reg;
        seen_e_next     = seen_e_reg;
        prev_e_next     = prev_e_reg;
        seen_point_next = seen_point_reg;
        mant_sign_next  = mant_sign_reg;
        exp_sign_next   = exp_sign_reg;
        mant_cnt_next   = mant_cnt_reg;
        exp_cnt_next    = exp_cnt_reg;
        err_next        = err_reg;
        if (step.valid) begin
            if (step.last) begin
                at_first_next   = 1'b1;
                seen_e_next     = 1'b0;
                prev_e_next     = 1'b0;
                seen_point_next = 1'b0;
                mant_sign_next  = 1'b0;
                exp_sign_next   = 1'b0;
                mant_cnt_next   = '0;
                exp_cnt_next    = '0;
                err_next        = flv_pkg::ST_OK;
            end else begin
                at_first_next   = 1'b0;
                seen_e_next     = seen_e_upd;
                prev_e_next     = prev_e_upd;
                seen_point_next = seen_point_upd;
                mant_sign_next  = mant_sign_upd;
                exp_sign_next   = exp_sign_upd;
                mant_cnt_next   = mant_cnt_upd;
                exp_cnt_next    = exp_cnt_upd;
                err_next        = err_upd;
            end
        end
    end

    // String state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_first_reg   <= 1'b1;
            seen_e_reg     <= 1'b0;
            prev_e_reg     <= 1'b0;
            seen_point_reg <= 1'b0;
            mant_sign_reg  <= 1'b0;
            exp_sign_reg   <= 1'b0;
            mant_cnt_reg   <= '0;
            exp_cnt_reg    <= '0;
            err_reg        <= flv_pkg::ST_OK;
        end else begin
            at_first_reg   <= at_first_next;
            seen_e_reg     <= seen_e_next;
            prev_e_reg     <= prev_e_next;
            seen_point_reg <= seen_point_next;
            mant_sign_reg  <= mant_sign_next;
            exp_sign_reg   <= exp_sign_next;
            mant_cnt_reg   <= mant_cnt_next;
            exp_cnt_reg    <= exp_cnt_next;
            err_reg        <= err_next;
        end
    end

    // A finished string leaves the scanner fully cleared.
    `FLV_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, step.valid && step.last,
        at_first_reg && (mant_cnt_reg == '0) && (exp_cnt_reg == '0) &&
        (err_reg == flv_pkg::ST_OK))

    // Once an error is latched, the digit counts stay frozen until the end.
    `FLV_ASSERT_NEXT(a_frozen_counts, aclk, aresetn,
        (err_reg != flv_pkg::ST_OK) && !(step.valid && step.last),
        $stable(mant_cnt_reg) && $stable(exp_cnt_reg))

endmodule

// ----- rtl/float_literal_validator.sv -----
// Top level of the float literal validator: channel registers, limit registers
// and the scanner. Depends on flv_pkg, flv_scan and float_literal_validator_assert.svh.
//
// Usage: a literal streams in on the s_ channel, one character per transaction,
// with s_last_char high on its final character. For every string, exactly one
// transaction leaves on the m_ channel, carrying m_status (0 means well formed).
// Characters other than the last produce no output.
// The limit registers are written on the cfg_ channel (index 0: mantissa digit
// limit, index 1: exponent digit limit); cfg_ready is always high. Write them
// only while no string is in flight.
// Timing: a character is held in the input register and is judged from there into the
// output register; m_valid rises once the final character has been judged, and the
// status is then held there until it is taken. One character is taken every cycle;
// the only thing that slows the input is the output register: while a status waits
// on a low m_ready, a further final character holds in the input register and s_ready
// drops once that register is full. Characters that are not final keep flowing past
// a stalled output.
// Reset: synchronous and active low; it empties both registers, clears the
// string state and loads the limits to 30 and 5.
`include "float_literal_validator_assert.svh"

module float_literal_validator (
    input  logic       aclk,
    input  logic       aresetn,
    // Character input.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_last_char,
    // Status output.
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    // Configuration writes.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    logic                      in_valid_reg, in_valid_next;
    logic                      in_last_reg;
    logic [7:0]                in_char_reg;
    logic                      m_valid_reg, m_valid_next;
    flv_pkg::flv_status_t      m_status_reg;
    logic [flv_pkg::CNT_W-1:0] mant_limit_reg, exp_limit_reg;
    logic                      advance;
    flv_pkg::flv_step_t        step;
    flv_pkg::flv_status_t      verdict;

    // A character moves on unless it is final and the output is still occupied.
    assign advance = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign step.valid     = advance;
    assign step.last      = in_last_reg;
    assign step.char_code = in_char_reg;

    flv_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .mant_limit (mant_limit_reg),
        .exp_limit  (exp_limit_reg),
        .verdict    (verdict)
    );

    // Channel occupancy.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance && in_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers and limit registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            mant_limit_reg <= flv_pkg::MANT_LIMIT_RST;
            exp_limit_reg  <= flv_pkg::EXP_LIMIT_RST;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    flv_pkg::CFG_IDX_MANT: mant_limit_reg <= cfg_data;
                    flv_pkg::CFG_IDX_EXP:  exp_limit_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_last_char;
        end
        if (advance && in_last_reg) begin
            m_status_reg <= verdict;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

    // An empty input register never blocks the sender.
    `FLV_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_ready)

    // A judged final character always shows up as a result.
    `FLV_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, advance && in_last_reg,
        m_valid_reg)

    // A result that was taken is not repeated unless a new final character came.
    `FLV_ASSERT_NEXT(a_no_extra_result, aclk, aresetn,
        m_valid_reg && m_ready && !(advance && in_last_reg), !m_valid_reg)

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for float_literal_validator: directed literals, then random ones.
// Depends on flv_pkg and the float_literal_validator RTL; it needs no other file.

module tb;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int CHARS_PER_PHASE = 195;
    localparam int N_PHASES        = 9;
    localparam int N_DIR           = 14;
    localparam int DRAIN_CYCLES    = 4;
    localparam string SYNTAX_CHARS = "0123456789.eE+-";

    // Scanner state of the predictor.
    typedef struct packed {
        logic                      at_first;
        logic                      seen_exp;
        logic                      prev_exp;
        logic                      seen_point;
        logic                      mant_signed;
        logic                      exp_signed;
        logic [flv_pkg::CNT_W-1:0] mant_cnt;
        logic [flv_pkg::CNT_W-1:0] exp_cnt;
        flv_pkg::flv_status_t      err;
    } lit_state_t;

    localparam lit_state_t LIT_CLEAR = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                         '0, '0, flv_pkg::ST_OK};

    // One row of the directed table.
    typedef struct {
        bit                   set_limits;
        bit [6:0]             mant_lim;
        bit [6:0]             exp_lim;
        string                text;
        int                   raw_code;   // >= 0: a single character with this code
        bit                   typed;
        flv_pkg::flv_status_t status;
    } dir_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_code = '0;
    logic       s_last_char = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_status;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [6:0] cfg_data = '0;

    lit_state_t                lit = LIT_CLEAR;
    logic [flv_pkg::CNT_W-1:0] lim_mant = flv_pkg::MANT_LIMIT_RST;
    logic [flv_pkg::CNT_W-1:0] lim_exp  = flv_pkg::EXP_LIMIT_RST;
    flv_pkg::flv_status_t      status_fifo[$];
    logic [7:0]                lit_chars[$];
    dir_row_t                  dir_rows[0:N_DIR-1];

    bit                   use_typed = 1'b0;
    flv_pkg::flv_status_t typed_status = flv_pkg::ST_OK;
    int                   s_idle_pct = 0;
    int                   m_idle_pct = 0;
    int                   cycle_count = 0;
    int                   char_count = 0;
    int                   string_count = 0;
    int                   result_count = 0;
    int                   error_count = 0;
    int                   setting_count = 0;

    float_literal_validator DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_code(s_char_code),
        .s_last_char(s_last_char),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d status results outstanding", $time,
                     status_fifo.size());
            $display("float_literal_validator regression: fail");
            $finish;
        end
    end

    // The receiver stalls at random, at the rate of the current pattern.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    function automatic logic [flv_pkg::CNT_W-1:0] sat_inc(
        input logic [flv_pkg::CNT_W-1:0] n);
        return (n == flv_pkg::COUNT_MAX) ? n : n + 7'd1;
    endfunction

    // Applies one character to the scanner state; only called while no error is held.
    function automatic void scan_literal_char(input logic [7:0] c);
        logic mark_now;
        mark_now = 1'b0;
        if (c >= flv_pkg::CH_ZERO && c <= flv_pkg::CH_NINE) begin
            if (!lit.seen_exp) lit.mant_cnt = sat_inc(lit.mant_cnt);
            else lit.exp_cnt = sat_inc(lit.exp_cnt);
        end else if (c == flv_pkg::CH_LOWER_E || c == flv_pkg::CH_UPPER_E) begin
            if (lit.seen_exp) lit.err = flv_pkg::ST_EXTRA_E;
            lit.seen_exp = 1'b1;
            mark_now = 1'b1;
        end else if (c == flv_pkg::CH_POINT) begin
            if (lit.seen_point) lit.err = flv_pkg::ST_EXTRA_POINT;
            else if (lit.seen_exp) lit.err = flv_pkg::ST_POINT_IN_EXP;
            lit.seen_point = 1'b1;
        end else if (c == flv_pkg::CH_PLUS || c == flv_pkg::CH_MINUS) begin
            if (!lit.seen_exp && !lit.mant_signed && lit.at_first) begin
                lit.mant_signed = 1'b1;
            end else if (lit.seen_exp && lit.prev_exp && !lit.exp_signed) begin
                lit.exp_signed = 1'b1;
            end else begin
                lit.err = flv_pkg::ST_BAD_SIGN;
            end
        end else begin
            lit.err = flv_pkg::ST_BAD_CHAR;
        end
        lit.prev_exp = mark_now;
    endfunction

    // Final status of a string: length limits override any earlier error.
    function automatic flv_pkg::flv_status_t literal_verdict();
        flv_pkg::flv_status_t st;
        st = lit.err;
        if (lit.mant_cnt > lim_mant) st = flv_pkg::ST_MANT_LONG;
        if (lit.exp_cnt > lim_exp) st = flv_pkg::ST_EXP_LONG;
        return st;
    endfunction

    // Tracks every accepted character transaction and predicts the status of each string at its final character.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            char_count++;
            if (lit.err == flv_pkg::ST_OK) scan_literal_char(s_char_code);
            lit.at_first = 1'b0;
            if (s_last_char) begin
                status_fifo.push_back(use_typed ? typed_status : literal_verdict());
                string_count++;
                lit = LIT_CLEAR;
            end
        end
    end

    // Tracks the limit registers on every configuration transaction.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == flv_pkg::CFG_IDX_MANT) lim_mant = cfg_data;
            else lim_exp = cfg_data;
        end
    end

    // Compares each status transaction with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (status_fifo.size() == 0) begin
                $display("%0t: unexpected status, expected none, actual %0d", $time, m_status);
                error_count++;
            end else begin
                if (m_status !== status_fifo[0]) begin
                    $display("%0t: status mismatch, expected %0d (%s), actual %0d", $time,
                             status_fifo[0], status_fifo[0].name(), m_status);
                    error_count++;
                end
                void'(status_fifo.pop_front());
            end
        end
    end

    // Drives one character and waits until it is accepted.
    task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
                             input flv_pkg::flv_status_t st);
        @(negedge aclk);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_char_code  <= c;
        s_last_char  <= last;
        use_typed    <= typed;
        typed_status <= st;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic send_literal(input bit typed, input flv_pkg::flv_status_t st);
        for (int k = 0; k < lit_chars.size(); k++) begin
            send_char(lit_chars[k], k == lit_chars.size() - 1, typed, st);
        end
    endtask

    // Stops sending and lets every predicted status come out.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (status_fifo.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Digit count for a random literal: mostly short, often near a limit of 24 or less, rarely at or near saturation.
    function automatic int pick_digit_count(input logic [flv_pkg::CNT_W-1:0] limit);
        int r;
        int n;
        r = $urandom_range(0, 199);
        if (r < 3) return $urandom_range(120, 130);
        if (r < 70 && limit <= 24) begin
            n = int'(limit) + $urandom_range(0, 2) - 1;
            return (n < 0) ? 0 : n;
        end
        return $urandom_range(0, 4);
    endfunction

    // Builds one random literal: well formed, broken by one edit, or plain noise.
    task automatic make_literal();
        int         kind;
        int         nm;
        int         ne;
        int         pt;
        int         pos;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        lit_chars.delete();
        if (kind < 85) begin
            if ($urandom_range(0, 2) == 0)
                lit_chars.push_back($urandom_range(0, 1) ? flv_pkg::CH_PLUS
                                                         : flv_pkg::CH_MINUS);
            nm = pick_digit_count(lim_mant);
            pt = $urandom_range(0, 1) ? int'($urandom_range(0, nm)) : -1;
            for (int k = 0; k <= nm; k++) begin
                if (k == pt) lit_chars.push_back(flv_pkg::CH_POINT);
                if (k < nm) lit_chars.push_back(flv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 1)) begin
                lit_chars.push_back($urandom_range(0, 1) ? flv_pkg::CH_UPPER_E
                                                         : flv_pkg::CH_LOWER_E);
                if ($urandom_range(0, 1))
                    lit_chars.push_back($urandom_range(0, 1) ? flv_pkg::CH_PLUS
                                                             : flv_pkg::CH_MINUS);
                ne = pick_digit_count(lim_exp);
                repeat (ne) lit_chars.push_back(flv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if (lit_chars.size() == 0)
                lit_chars.push_back(flv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            // Break the literal with one replaced or inserted character.
            if (kind >= 70) begin
                pos = $urandom_range(0, lit_chars.size() - 1);
                c = $urandom_range(0, 1) ? 8'(SYNTAX_CHARS[$urandom_range(0, 14)])
                                         : 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1)) lit_chars[pos] = c;
                else lit_chars.insert(pos, c);
            end
        end else begin
            repeat ($urandom_range(1, 6)) begin
                c = $urandom_range(0, 1) ? 8'(SYNTAX_CHARS[$urandom_range(0, 14)])
                                         : 8'($urandom_range(0, 255));
                lit_chars.push_back(c);
            end
        end
    endtask

    initial begin
        int phase_mant[N_PHASES];
        int phase_exp[N_PHASES];
        int ph_chars;

        // Directed literals; the first group runs with the limits from reset.
        dir_rows[0]  = '{0, 0, 0, "0",       -1,  1, flv_pkg::ST_OK};
        dir_rows[1]  = '{0, 0, 0, "-1.5e+3", -1,  0, flv_pkg::ST_OK};
        dir_rows[2]  = '{0, 0, 0, "ee",      -1,  1, flv_pkg::ST_EXTRA_E};
        dir_rows[3]  = '{0, 0, 0, "..",      -1,  1, flv_pkg::ST_EXTRA_POINT};
        dir_rows[4]  = '{0, 0, 0, "e.",      -1,  1, flv_pkg::ST_POINT_IN_EXP};
        dir_rows[5]  = '{0, 0, 0, "1+",      -1,  1, flv_pkg::ST_BAD_SIGN};
        dir_rows[6]  = '{0, 0, 0, "a",       -1,  1, flv_pkg::ST_BAD_CHAR};
        dir_rows[7]  = '{0, 0, 0, "",        0,   1, flv_pkg::ST_BAD_CHAR};
        dir_rows[8]  = '{0, 0, 0, "",        255, 1, flv_pkg::ST_BAD_CHAR};
        // Zero limits: any digit is too long, and the exponent check wins over the mantissa.
        dir_rows[9]  = '{1, 0, 0, "5",       -1,  1, flv_pkg::ST_MANT_LONG};
        dir_rows[10] = '{0, 0, 0, "e5",      -1,  1, flv_pkg::ST_EXP_LONG};
        dir_rows[11] = '{0, 0, 0, "1a",      -1,  1, flv_pkg::ST_MANT_LONG};
        dir_rows[12] = '{0, 0, 0, "1e1",     -1,  1, flv_pkg::ST_EXP_LONG};
        // Limits at their maximum of 127.
        dir_rows[13] = '{1, 127, 127, "9E",  -1,  0, flv_pkg::ST_OK};

        // Limit settings of the random phases; a negative entry draws a small random limit.
        phase_mant = '{0, 126, 127, -1, 3, 0,   -1, 8, 30};
        phase_exp  = '{0, 126, 0,   -1, 1, 127, -1, 2, 5};

        s_idle_pct = 20;
        m_idle_pct = 59;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        setting_count = 1;

        for (int i = 0; i < N_DIR; i++) begin
            if (dir_rows[i].set_limits) begin
                drain_results();
                write_reg(flv_pkg::CFG_IDX_MANT, dir_rows[i].mant_lim);
                write_reg(flv_pkg::CFG_IDX_EXP, dir_rows[i].exp_lim);
                setting_count++;
            end
            lit_chars.delete();
            if (dir_rows[i].raw_code >= 0) begin
                lit_chars.push_back(8'(dir_rows[i].raw_code));
            end else begin
                for (int k = 0; k < dir_rows[i].text.len(); k++) begin
                    lit_chars.push_back(dir_rows[i].text[k]);
                end
            end
            send_literal(dir_rows[i].typed, dir_rows[i].status);
        end

        // Random phases: three idling patterns, three limit settings each.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph / 3)
                0: begin
                    s_idle_pct = 20;
                    m_idle_pct = 59;
                end
                1: begin
                    s_idle_pct = 59;
                    m_idle_pct = 20;
                end
                default: begin
                    s_idle_pct = 0;
                    m_idle_pct = 0;
                end
            endcase
            drain_results();
            write_reg(flv_pkg::CFG_IDX_MANT,
                      (phase_mant[ph] < 0) ? 7'($urandom_range(0, 12)) : 7'(phase_mant[ph]));
            write_reg(flv_pkg::CFG_IDX_EXP,
                      (phase_exp[ph] < 0) ? 7'($urandom_range(0, 12)) : 7'(phase_exp[ph]));
            setting_count++;
            ph_chars = 0;
            while (ph_chars < CHARS_PER_PHASE) begin
                make_literal();
                ph_chars += lit_chars.size();
                send_literal(1'b0, flv_pkg::ST_OK);
                // Now and then the sender holds off until the output side is empty.
                if ($urandom_range(0, 39) == 0) drain_results();
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        drain_results();
        repeat (8) @(posedge aclk);

        $display("Checked %0d literals (%0d characters, %0d status results) under %0d limit",
                 string_count, char_count, result_count, setting_count);
        $display("settings and three idling patterns; %0d mismatches.", error_count);
        if (error_count == 0) begin
            $display("float_literal_validator regression: pass");
        end else begin
            $display("float_literal_validator regression: fail");
        end
        $finish;
    end

endmodule

// ----- float_literal_validator.f -----
+incdir+rtl
rtl/flv_pkg.sv
rtl/flv_scan.sv
rtl/float_literal_validator.sv
tb/sv/tb.sv
